### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the RTL. They compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

### rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Types, constants and the microcode table of the sprite tile expander.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

  localparam int UADDR_W = 4;
  typedef logic [UADDR_W-1:0] uaddr_t;

  // Microcode step addresses.
  localparam uaddr_t UA_WAIT     = 4'd0;
  localparam uaddr_t UA_ORIGIN   = 4'd1;
  localparam uaddr_t UA_ADJUST   = 4'd2;
  localparam uaddr_t UA_ROW_CHK  = 4'd3;
  localparam uaddr_t UA_ABOVE    = 4'd4;
  localparam uaddr_t UA_SKIP     = 4'd5;
  localparam uaddr_t UA_COL_INIT = 4'd6;
  localparam uaddr_t UA_TILE     = 4'd7;
  localparam uaddr_t UA_NEXT_ROW = 4'd8;
  localparam uaddr_t UA_FLUSH    = 4'd9;

  // Configuration register indexes and reset values.
  localparam logic REG_CLIP_TOP    = 1'b0;
  localparam logic REG_CLIP_BOTTOM = 1'b1;
  localparam logic [7:0] CLIP_TOP_RST    = 8'd0;
  localparam logic [7:0] CLIP_BOTTOM_RST = 8'd239;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_LOAD     = 4'd1,
    OP_ORIGIN   = 4'd2,
    OP_ADJUST   = 4'd3,
    OP_SKIP_ROW = 4'd4,
    OP_COL_INIT = 4'd5,
    OP_TILE     = 4'd6,
    OP_NEXT_ROW = 4'd7,
    OP_FLUSH    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_ALWAYS    = 3'd1,
    C_ROW_DONE  = 3'd2,
    C_NOT_ABOVE = 3'd3,
    C_BELOW     = 3'd4,
    C_COL_MORE  = 3'd5
  } cond_t;

  typedef struct packed {
    op_t    op;
    cond_t  cond;
    uaddr_t target;
    logic   wait_in;
  } ucode_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_t  op;
    logic fire;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic row_done;
    logic above;
    logic below;
    logic col_more;
    logic blocked;
    logic pend_v;
  } stat_t;

  function automatic ucode_t ucode_rom(input uaddr_t addr);
    ucode_t w;
    case (addr)
      UA_WAIT:     w = '{op: OP_LOAD,     cond: C_NEXT,      target: UA_WAIT,     wait_in: 1'b1};
      UA_ORIGIN:   w = '{op: OP_ORIGIN,   cond: C_NEXT,      target: UA_WAIT,     wait_in: 1'b0};
      UA_ADJUST:   w = '{op: OP_ADJUST,   cond: C_NEXT,      target: UA_WAIT,     wait_in: 1'b0};
      UA_ROW_CHK:  w = '{op: OP_NOP,      cond: C_ROW_DONE,  target: UA_FLUSH,    wait_in: 1'b0};
      UA_ABOVE:    w = '{op: OP_NOP,      cond: C_NOT_ABOVE, target: UA_COL_INIT, wait_in: 1'b0};
      UA_SKIP:     w = '{op: OP_SKIP_ROW, cond: C_ALWAYS,    target: UA_ROW_CHK,  wait_in: 1'b0};
      UA_COL_INIT: w = '{op: OP_COL_INIT, cond: C_BELOW,     target: UA_FLUSH,    wait_in: 1'b0};
      UA_TILE:     w = '{op: OP_TILE,     cond: C_COL_MORE,  target: UA_TILE,     wait_in: 1'b0};
      UA_NEXT_ROW: w = '{op: OP_NEXT_ROW, cond: C_ALWAYS,    target: UA_ROW_CHK,  wait_in: 1'b0};
      UA_FLUSH:    w = '{op: OP_FLUSH,    cond: C_ALWAYS,    target: UA_WAIT,     wait_in: 1'b0};
      default:     w = '{op: OP_NOP,      cond: C_ALWAYS,    target: UA_WAIT,     wait_in: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/ste_cfg.sv
// ----------------------------------------------------------------------------
// ste_cfg
// APB-style register file holding the clip window.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [7:0]  clip_top,
  output logic      [7:0]  clip_bottom
);

  logic [7:0] clip_top_r, clip_top_nxt;
  logic [7:0] clip_bottom_r, clip_bottom_nxt;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    clip_top_nxt    = clip_top_r;
    clip_bottom_nxt = clip_bottom_r;
    if (wr_en) begin
      case (reg_idx)
        ste_pkg::REG_CLIP_TOP:    clip_top_nxt    = pwdata[7:0];
        ste_pkg::REG_CLIP_BOTTOM: clip_bottom_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_top_r    <= ste_pkg::CLIP_TOP_RST;
      clip_bottom_r <= ste_pkg::CLIP_BOTTOM_RST;
    end else begin
      clip_top_r    <= clip_top_nxt;
      clip_bottom_r <= clip_bottom_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      ste_pkg::REG_CLIP_TOP:    prdata = {24'd0, clip_top_r};
      ste_pkg::REG_CLIP_BOTTOM: prdata = {24'd0, clip_bottom_r};
      default:                  prdata = 32'd0;
    endcase
  end

  assign clip_top    = clip_top_r;
  assign clip_bottom = clip_bottom_r;

endmodule

`default_nettype wire

### rtl/ste_seq.sv
// ----------------------------------------------------------------------------
// ste_seq
// Microprogram counter, control store lookup and branch selection.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire ste_pkg::stat_t stat,
  output logic                in_ready,
  output ste_pkg::ctrl_t      ctrl
);

  ste_pkg::uaddr_t upc_r, upc_nxt;
  ste_pkg::ucode_t uw;
  logic            taken;
  logic            fire;

  assign uw = ste_pkg::ucode_rom(upc_r);

  always_comb begin
    case (uw.cond)
      ste_pkg::C_NEXT:      taken = 1'b0;
      ste_pkg::C_ALWAYS:    taken = 1'b1;
      ste_pkg::C_ROW_DONE:  taken = stat.row_done;
      ste_pkg::C_NOT_ABOVE: taken = !stat.above;
      ste_pkg::C_BELOW:     taken = stat.below;
      ste_pkg::C_COL_MORE:  taken = stat.col_more;
      default:              taken = 1'b1;
    endcase
  end

  // A step holds while it waits for an input item or for room on the output.
  assign fire = !(uw.wait_in && !in_valid) && !stat.blocked;

  always_comb begin
    upc_nxt = upc_r;
    if (fire) begin
      upc_nxt = taken ? uw.target : upc_r + ste_pkg::UADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ste_pkg::UA_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign in_ready  = uw.wait_in;
  assign ctrl.op   = uw.op;
  assign ctrl.fire = fire;

endmodule

`default_nettype wire

### rtl/ste_dpath.sv
// ----------------------------------------------------------------------------
// ste_dpath
// Object registers, tile walk arithmetic, one-deep hold stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_dpath #(
  parameter int SCREEN_WIDTH  = 336,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ste_pkg::ctrl_t ctrl,
  output ste_pkg::stat_t      stat,
  input  wire logic [7:0]     clip_top,
  input  wire logic [7:0]     clip_bottom,
  input  wire logic [15:0]    in_image_word,
  input  wire logic [15:0]    in_horizontal_word,
  input  wire logic [15:0]    in_vertical_word,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [12:0]         out_tile_image,
  output logic [3:0]          out_palette,
  output logic                out_mirror,
  output logic signed [9:0]   out_screen_x,
  output logic signed [8:0]   out_screen_y,
  output logic                out_last
);

  localparam logic signed [11:0] SW_S   = 12'(SCREEN_WIDTH);
  localparam logic signed [11:0] SH_S   = 12'(SCREEN_HEIGHT);
  localparam logic signed [11:0] WRAP_S = 12'sd512;
  localparam logic signed [11:0] TILE_S = 12'sd8;

  // Object registers.
  logic [12:0]        tile_r, tile_nxt;
  logic [3:0]         pal_r, pal_nxt;
  logic               mir_r, mir_nxt;
  logic [2:0]         wm1_r, wm1_nxt;
  logic [2:0]         hm1_r, hm1_nxt;
  logic signed [11:0] xo_r, xo_nxt;
  logic signed [11:0] sy_r, sy_nxt;
  logic signed [11:0] sx_r, sx_nxt;
  logic [3:0]         row_r, row_nxt;
  logic [2:0]         col_r, col_nxt;

  // Hold stage: the newest tile waits here until we know whether it is the last.
  logic               pend_v_r, pend_v_nxt;
  logic [12:0]        pend_tile_r, pend_tile_nxt;
  logic [9:0]         pend_sx_r, pend_sx_nxt;
  logic [8:0]         pend_sy_r, pend_sy_nxt;

  // Output register.
  logic               out_v_r, out_v_nxt;
  logic [12:0]        out_tile_r, out_tile_nxt;
  logic [3:0]         out_pal_r, out_pal_nxt;
  logic               out_mir_r, out_mir_nxt;
  logic [9:0]         out_sx_r, out_sx_nxt;
  logic [8:0]         out_sy_r, out_sy_nxt;
  logic               out_last_r, out_last_nxt;

  logic [3:0]         high;
  logic [3:0]         wide;
  logic signed [11:0] sy_plus8;
  logic               visible;
  logic               out_free;
  logic [8:0]         x_wrap;
  logic [8:0]         y_wrap;
  logic signed [11:0] x_step;

  assign high     = {1'b0, hm1_r} + 4'd1;
  assign wide     = {1'b0, wm1_r} + 4'd1;
  assign sy_plus8 = sy_r + TILE_S;
  assign visible  = (sx_r > -TILE_S) && (sx_r < SW_S);
  assign out_free = !out_v_r || out_ready;
  assign x_step   = mir_r ? -TILE_S : TILE_S;

  assign x_wrap = xo_r[8:0] + (mir_r ? {3'b000, wm1_r, 3'b000} : 9'd0);
  assign y_wrap = 9'd0 - sy_r[8:0] - {2'b00, high, 3'b000};

  assign stat.row_done = (row_r == high);
  assign stat.above    = (sy_plus8 <= $signed({4'b0000, clip_top}));
  assign stat.below    = (sy_r > $signed({4'b0000, clip_bottom}));
  assign stat.col_more = (col_r != wm1_r);
  assign stat.pend_v   = pend_v_r;
  assign stat.blocked  = pend_v_r && !out_free &&
                         ((ctrl.op == ste_pkg::OP_TILE && visible) ||
                          (ctrl.op == ste_pkg::OP_FLUSH));

  always_comb begin
    tile_nxt      = tile_r;
    pal_nxt       = pal_r;
    mir_nxt       = mir_r;
    wm1_nxt       = wm1_r;
    hm1_nxt       = hm1_r;
    xo_nxt        = xo_r;
    sy_nxt        = sy_r;
    sx_nxt        = sx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pend_v_nxt    = pend_v_r;
    pend_tile_nxt = pend_tile_r;
    pend_sx_nxt   = pend_sx_r;
    pend_sy_nxt   = pend_sy_r;
    out_v_nxt     = out_v_r && !out_ready;
    out_tile_nxt  = out_tile_r;
    out_pal_nxt   = out_pal_r;
    out_mir_nxt   = out_mir_r;
    out_sx_nxt    = out_sx_r;
    out_sy_nxt    = out_sy_r;
    out_last_nxt  = out_last_r;

    if (ctrl.fire) begin
      case (ctrl.op)
        ste_pkg::OP_LOAD: begin
          tile_nxt = {1'b0, in_image_word[11:0]};
          pal_nxt  = in_horizontal_word[3:0];
          mir_nxt  = in_vertical_word[3];
          wm1_nxt  = in_vertical_word[6:4];
          hm1_nxt  = in_vertical_word[2:0];
          xo_nxt   = {3'b000, in_horizontal_word[15:7]};
          sy_nxt   = {3'b000, in_vertical_word[15:7]};
          row_nxt  = 4'd0;
        end
        ste_pkg::OP_ORIGIN: begin
          xo_nxt = {3'b000, x_wrap};
          sy_nxt = {3'b000, y_wrap};
        end
        ste_pkg::OP_ADJUST: begin
          if (xo_r >= SW_S) xo_nxt = xo_r - WRAP_S;
          if (sy_r >= SH_S) sy_nxt = sy_r - WRAP_S;
        end
        ste_pkg::OP_SKIP_ROW: begin
          tile_nxt = tile_r + {9'd0, wide};
          sy_nxt   = sy_plus8;
          row_nxt  = row_r + 4'd1;
        end
        ste_pkg::OP_COL_INIT: begin
          sx_nxt  = xo_r;
          col_nxt = 3'd0;
        end
        ste_pkg::OP_TILE: begin
          if (visible) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_tile_nxt = pend_tile_r;
              out_pal_nxt  = pal_r;
              out_mir_nxt  = mir_r;
              out_sx_nxt   = pend_sx_r;
              out_sy_nxt   = pend_sy_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_tile_nxt = tile_r;
            pend_sx_nxt   = sx_r[9:0];
            pend_sy_nxt   = sy_r[8:0];
          end
          tile_nxt = tile_r + 13'd1;
          sx_nxt   = sx_r + x_step;
          col_nxt  = col_r + 3'd1;
        end
        ste_pkg::OP_NEXT_ROW: begin
          sy_nxt  = sy_plus8;
          row_nxt = row_r + 4'd1;
        end
        ste_pkg::OP_FLUSH: begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_tile_nxt = pend_tile_r;
            out_pal_nxt  = pal_r;
            out_mir_nxt  = mir_r;
            out_sx_nxt   = pend_sx_r;
            out_sy_nxt   = pend_sy_r;
            out_last_nxt = 1'b1;
            pend_v_nxt   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tile_r      <= tile_nxt;
    pal_r       <= pal_nxt;
    mir_r       <= mir_nxt;
    wm1_r       <= wm1_nxt;
    hm1_r       <= hm1_nxt;
    xo_r        <= xo_nxt;
    sy_r        <= sy_nxt;
    sx_r        <= sx_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    pend_tile_r <= pend_tile_nxt;
    pend_sx_r   <= pend_sx_nxt;
    pend_sy_r   <= pend_sy_nxt;
    out_tile_r  <= out_tile_nxt;
    out_pal_r   <= out_pal_nxt;
    out_mir_r   <= out_mir_nxt;
    out_sx_r    <= out_sx_nxt;
    out_sy_r    <= out_sy_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_v_r;
  assign out_tile_image = out_tile_r;
  assign out_palette    = out_pal_r;
  assign out_mirror     = out_mir_r;
  assign out_screen_x   = out_sx_r;
  assign out_screen_y   = out_sy_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

### rtl/sprite_tile_expander.sv
// Latency: a visible tile enters the output register at the end of the step that finds the
// next visible tile of the object, or at the final flush step for the last tile.
// Steps: load, origin, adjust; per row walked a row check, above check, column init, a tile
// step per column, next row (a row above the window: row check, above check, skip); flush.
// The sequencer walks one step per cycle unless stalled; one item is in work at a time.
// Reset: synchronous, active low; clears the step counter and valids, resets the clip window.
// ----------------------------------------------------------------------------
// sprite_tile_expander
// Expands one motion-object entry into 8x8 tile draw commands under a microcoded walk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sprite_tile_expander #(
  parameter int SCREEN_WIDTH  = 336,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [15:0] in_image_word,
  input  wire logic        [15:0] in_horizontal_word,
  input  wire logic        [15:0] in_vertical_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [12:0] out_tile_image,
  output logic             [3:0]  out_palette,
  output logic                    out_mirror,
  output logic signed      [9:0]  out_screen_x,
  output logic signed      [8:0]  out_screen_y,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [2:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  ste_pkg::ctrl_t ctrl;
  ste_pkg::stat_t stat;
  logic [7:0]     clip_top;
  logic [7:0]     clip_bottom;

  ste_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .clip_top    (clip_top),
    .clip_bottom (clip_bottom)
  );

  ste_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  ste_dpath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .clip_top           (clip_top),
    .clip_bottom        (clip_bottom),
    .in_image_word      (in_image_word),
    .in_horizontal_word (in_horizontal_word),
    .in_vertical_word   (in_vertical_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tile_image     (out_tile_image),
    .out_palette        (out_palette),
    .out_mirror         (out_mirror),
    .out_screen_x       (out_screen_x),
    .out_screen_y       (out_screen_y),
    .out_last           (out_last)
  );

  // Once an item is taken the sequencer leaves the wait step.
  `ASSERT_NEXT(a_leave_wait, clk, rst_n, in_valid && in_ready, !in_ready)
  // The hold stage is always drained before a new item can be taken.
  `ASSERT_IMPLIES(a_drained_at_wait, clk, rst_n, in_ready, !stat.pend_v)
  // A step that waits on the output never advances.
  `ASSERT_IMPLIES(a_blocked_holds, clk, rst_n, stat.blocked, !ctrl.fire)

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Sprite tile expander testbench
// Feeds motion-object entries through the valid/ready input channel and checks
// every tile draw command against typed rows or a predictor of the expansion. A
// directed table covers the position, size and flip extremes, and random objects
// follow under several clip windows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SCREEN_W         = 336;
  localparam int SCREEN_H         = 240;
  localparam int SETTLE_CYCLES    = 160;
  localparam int STALL_LIMIT      = 3000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int N_DIRECTED       = 20;
  localparam int PREDICTED        = -1;

  typedef struct packed {
    logic [12:0]       image;
    logic [3:0]        palette;
    logic              mirror;
    logic signed [9:0] x;
    logic signed [8:0] y;
    logic              last;
  } tile_cmd_t;

  // One object entry; n is the number of tiles typed in below, or PREDICTED.
  typedef struct packed {
    logic [15:0] iw;
    logic [15:0] hw;
    logic [15:0] vw;
    int          n;
    int          img;
    int          pal;
    int          mir;
    int          x;
    int          y;
  } object_row_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [15:0] in_image_word = '0;
  logic [15:0] in_horizontal_word = '0;
  logic [15:0] in_vertical_word = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic [12:0] out_tile_image;
  logic [3:0] out_palette;
  logic out_mirror;
  logic signed [9:0] out_screen_x;
  logic signed [8:0] out_screen_y;
  logic out_last;
  logic [31:0] prdata;
  logic pready;

  tile_cmd_t tiles_due[$];
  logic [7:0] win_top;
  logic [7:0] win_bottom;
  int errors = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int ready_phase = 0;

  // Typed rows assume the clip window out of reset (0 to 239).
  object_row_t directed [N_DIRECTED] = '{
    '{16'h0123, 16'h0005, 16'hFC00, 1, 'h123, 5, 0, 0, 0},
    '{16'h0FFF, 16'hA78A, 16'hFC00, 1, 'hFFF, 10, 0, 335, 0},
    '{16'h0456, 16'hA800, 16'hFC00, 0, 0, 0, 0, 0, 0},
    '{16'hF000, 16'hFC80, 16'hFC00, 1, 0, 0, 0, -7, 0},
    '{16'h0001, 16'hFC00, 16'hFC00, 0, 0, 0, 0, 0, 0},
    '{16'h0800, 16'h0000, 16'h8480, 1, 'h800, 0, 0, 0, 239},
    '{16'h0802, 16'h0000, 16'h8400, 0, 0, 0, 0, 0, 0},
    '{16'h0003, 16'h000F, 16'hFF80, 1, 3, 15, 0, 0, -7},
    '{16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0},
    '{16'h0042, 16'h0003, 16'hFC08, 1, 'h42, 3, 1, 0, 0},
    '{16'h0FFF, 16'h0007, 16'hE07F, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0100, 16'hA00C, 16'hE077, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0200, 16'hEC01, 16'hE07F, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0300, 16'h1002, 16'hEA37, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0400, 16'h2004, 16'h7C77, PREDICTED, 0, 0, 0, 0, 0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0555, 16'h0079, 16'hFC00, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0AAA, 16'hFA06, 16'hFC78, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h07FF, 16'hA00E, 16'hFC18, PREDICTED, 0, 0, 0, 0, 0},
    '{16'h0FF8, 16'h5000, 16'hAE77, PREDICTED, 0, 0, 0, 0, 0}
  };

  sprite_tile_expander #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_image_word     (in_image_word),
    .in_horizontal_word(in_horizontal_word),
    .in_vertical_word  (in_vertical_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tile_image    (out_tile_image),
    .out_palette       (out_palette),
    .out_mirror        (out_mirror),
    .out_screen_x      (out_screen_x),
    .out_screen_y      (out_screen_y),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  // Walks the tile grid of one object and queues a draw command per visible tile.
  function automatic void expand_object(input logic [15:0] iw, input logic [15:0] hw,
                                        input logic [15:0] vw);
    int tile;
    int wide;
    int high;
    int step;
    int ox;
    int oy;
    int sx;
    int sy;
    bit held;
    tile_cmd_t cmd;
    tile_cmd_t prev;
    tile = int'(iw[11:0]);
    wide = int'(vw[6:4]) + 1;
    high = int'(vw[2:0]) + 1;
    step = vw[3] ? -8 : 8;
    ox = int'(hw[15:7]) + (vw[3] ? 8 * (wide - 1) : 0);
    oy = 512 - int'(vw[15:7]) - 8 * high;
    ox = ox & 'h1ff;
    oy = oy & 'h1ff;
    if (ox >= SCREEN_W) ox -= 512;
    if (oy >= SCREEN_H) oy -= 512;
    held = 1'b0;
    prev = '0;
    for (int row = 0; row < high; row++) begin
      sy = oy + 8 * row;
      // Rows above the window still consume their tile images.
      if (sy <= int'(win_top) - 8) begin
        tile += wide;
        continue;
      end
      if (sy > int'(win_bottom)) break;
      for (int col = 0; col < wide; col++) begin
        sx = ox + step * col;
        if (sx > -8 && sx < SCREEN_W) begin
          cmd.image = 13'(tile);
          cmd.palette = hw[3:0];
          cmd.mirror = vw[3];
          cmd.x = 10'(sx);
          cmd.y = 9'(sy);
          cmd.last = 1'b0;
          if (held) tiles_due.push_back(prev);
          prev = cmd;
          held = 1'b1;
        end
        tile++;
      end
    end
    if (held) begin
      prev.last = 1'b1;
      tiles_due.push_back(prev);
    end
  endfunction

  function automatic string show(input tile_cmd_t c);
    return $sformatf("image=%h palette=%0d mirror=%0d x=%0d y=%0d last=%0d",
                     c.image, c.palette, c.mirror, c.x, c.y, c.last);
  endfunction

  always @(negedge clk) begin
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(1));
      RDY_SPARSE: out_ready <= ($urandom_range(3) == 0);
      default: begin
        out_ready <= (ready_phase < 4) || (ready_phase == 7);
        ready_phase <= (ready_phase == 10) ? 0 : ready_phase + 1;
      end
    endcase
  end

  always @(posedge clk) begin : check_tiles
    tile_cmd_t got;
    tile_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_tile_image, out_palette, out_mirror, out_screen_x, out_screen_y, out_last};
      if (tiles_due.size() == 0) begin
        errors++;
        if (errors <= SHOWN_MISMATCHES) $display("unexpected tile: %s", show(got));
      end else begin
        want = tiles_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= SHOWN_MISMATCHES)
            $display("tile mismatch: expected %s, got %s", show(want), show(got));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("[sprite_tile_expander] ERROR");
    $finish;
  end

  task automatic push_item(input object_row_t r);
    tile_cmd_t cmd;
    @(negedge clk);
    in_valid <= 1'b1;
    in_image_word <= r.iw;
    in_horizontal_word <= r.hw;
    in_vertical_word <= r.vw;
    do @(posedge clk); while (!in_ready);
    if (r.n == PREDICTED) begin
      expand_object(r.iw, r.hw, r.vw);
    end else if (r.n == 1) begin
      cmd = '{13'(r.img), 4'(r.pal), 1'(r.mir), 10'(r.x), 9'(r.y), 1'b1};
      tiles_due.push_back(cmd);
    end
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops the sender until every queued tile has come out, then optionally lets
  // an object with no visible tile finish its walk.
  task automatic drain(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == ste_pkg::REG_CLIP_TOP) win_top = value;
    else win_bottom = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_window(input logic [7:0] top, input logic [7:0] bottom);
    drain(1'b1);
    cfg_write(ste_pkg::REG_CLIP_TOP, top);
    cfg_write(ste_pkg::REG_CLIP_BOTTOM, bottom);
  endtask

  // Most objects are placed so that they meet the clip window and the screen
  // edges; the rest are raw random words.
  task automatic send_random();
    object_row_t r;
    int w;
    int h;
    int lo;
    int hi;
    int y;
    int x;
    r = '0;
    r.n = PREDICTED;
    r.iw = 16'($urandom);
    r.hw = 16'($urandom);
    r.vw = 16'($urandom);
    if ($urandom_range(9) < 8) begin
      w = int'(r.vw[6:4]) + 1;
      h = int'(r.vw[2:0]) + 1;
      lo = int'(win_top) - 8 * h;
      hi = int'(win_bottom) + 8;
      if (hi < lo) hi = lo;
      y = lo + int'($urandom_range(hi - lo));
      r.vw[15:7] = 9'(512 - y - 8 * h);
      x = int'($urandom_range(SCREEN_W + 8 + 8 * w)) - 8 * w;
      r.hw[15:7] = 9'(x - (r.vw[3] ? 8 * (w - 1) : 0));
    end
    push_item(r);
  endtask

  task automatic run_random(input int count);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        ready_mode = ready_mode_t'($urandom_range(3));
        if ($urandom_range(7) == 0) drain(1'b0);
        else if ($urandom_range(3) != 0) pause_input($urandom_range(1, 8));
      end
      send_random();
      burst--;
    end
  endtask

  initial begin : stimulus
    logic [7:0] top;
    win_top = ste_pkg::CLIP_TOP_RST;
    win_bottom = ste_pkg::CLIP_BOTTOM_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == N_DIRECTED / 2) ready_mode = RDY_COIN;
      push_item(directed[i]);
      if (i % 5 == 4) pause_input($urandom_range(1, 5));
    end

    set_window(8'd16, 8'd200);
    run_random(20);
    // An inverted window shows nothing.
    set_window(8'd255, 8'd0);
    run_random(8);
    set_window(8'd0, 8'd255);
    run_random(30);
    set_window(8'd0, 8'd0);
    run_random(10);
    set_window(8'd255, 8'd255);
    run_random(4);
    top = 8'($urandom_range(120));
    set_window(top, 8'($urandom_range(255, int'(top))));
    run_random(28);
    drain(1'b1);

    if (errors == 0 && tiles_due.size() == 0) begin
      $display("[sprite_tile_expander] OK");
    end else begin
      $display("[sprite_tile_expander] ERROR");
    end
    $finish;
  end

endmodule
